>>> src/rfc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the character decoder for the RFID frame checker.
// No dependencies.
package rfc_pkg;

    localparam int NUM_READERS_DEFAULT = 2;

    localparam int CHAR_COUNT_W = 5;
    localparam int TAG_W        = 40;

    localparam logic [7:0] STX_CHAR = 8'h02;
    localparam logic [7:0] ETX_CHAR = 8'h03;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_F   = 8'h46;

    localparam logic [CHAR_COUNT_W-1:0] MIN_FRAME_CHARS     = 5'd12;
    localparam logic [CHAR_COUNT_W-1:0] COUNT_MAX           = 5'd31;
    localparam logic [CHAR_COUNT_W-1:0] MAX_FRAME_CHARS_RST = 5'd16;
    // byte slot (char_count / 2) that holds the check byte
    localparam logic [3:0]              CHECK_SLOT          = 4'd5;

    // closed, checksum-valid frame waiting for duplicate filtering
    typedef struct packed {
        logic             reader;
        logic [TAG_W-1:0] tag;
    } cand_t;

    // hex digits 0-9 and A-F to nibbles, anything else passes through raw
    function automatic logic [7:0] decode_char(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = c - CHAR_0;
        end else if (c >= CHAR_A && c <= CHAR_F) begin
            v = c - CHAR_A + 8'd10;
        end
        return v;
    endfunction

endpackage

>>> src/rfid_ascii_frame_checker.sv
`timescale 1ns / 1ps
// Top level of the RFID ASCII frame checker.
// Depends on rfc_pkg, rfc_front, rfc_queue, rfc_back.
// Usage:
//   s_ channel carries one received serial byte (s_rx_byte) and the reader it
//   came from (s_reader_id). STX restarts that reader's frame; ETX or the
//   configured character count closes it. A frame whose first five bytes XOR
//   to the sixth yields a 40-bit tag on the m_ channel with the reader number,
//   unless the tag equals the last one published (shared by all readers).
//   cfg_wr_en/cfg_wr_data set the closing character count; write it only
//   while the block is idle.
// Timing:
//   One byte accepted per cycle, back to back, while s_ready is high. The tag of
//   a closing byte passes through the queue and then the output register to m_valid.
// Reset:
//   Synchronous, active low. All frame state, the last tag and the queue are
//   cleared; the closing count returns to 16. s_ready is high right after.
// Stall:
//   While m_ready is low the output holds; up to two further tags queue up,
//   then s_ready drops until the output drains.
module rfid_ascii_frame_checker #(
    parameter int NUM_READERS = rfc_pkg::NUM_READERS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rfc_pkg::CHAR_COUNT_W-1:0]  cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_reader_id,
    input  logic [7:0]                        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_reader_number,
    output logic [rfc_pkg::TAG_W-1:0]         m_tag_id
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_not_empty;
    rfc_pkg::cand_t push_data;
    rfc_pkg::cand_t q_head;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    rfc_front #(
        .NUM_READERS (NUM_READERS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .reader_id   (s_reader_id),
        .rx_byte     (s_rx_byte),
        .push        (push),
        .push_data   (push_data)
    );

    rfc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rfc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (q_not_empty),
        .head            (q_head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reader_number (m_reader_number),
        .m_tag_id        (m_tag_id)
    );

endmodule

>>> src/rfc_front.sv
`timescale 1ns / 1ps
// Front end: per-reader framing, nibble pairing, XOR check, frame close.
// Depends on rfc_pkg.
module rfc_front #(
    parameter int NUM_READERS = rfc_pkg::NUM_READERS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rfc_pkg::CHAR_COUNT_W-1:0]  cfg_wr_data,
    input  logic                              accept,
    input  logic                              reader_id,
    input  logic [7:0]                        rx_byte,
    output logic                              push,
    output rfc_pkg::cand_t                    push_data
);

    logic [rfc_pkg::CHAR_COUNT_W-1:0] max_chars_reg;
    logic [rfc_pkg::CHAR_COUNT_W-1:0] count_reg [NUM_READERS];
    logic [7:0]                       hi_reg    [NUM_READERS];
    logic [rfc_pkg::TAG_W-1:0]        tag_reg   [NUM_READERS];
    logic [7:0]                       xor_reg   [NUM_READERS];
    logic [7:0]                       chk_reg   [NUM_READERS];

    logic [rfc_pkg::CHAR_COUNT_W-1:0] count_next;
    logic [7:0]                       hi_next;
    logic [rfc_pkg::TAG_W-1:0]        tag_next;
    logic [7:0]                       xor_next;
    logic [7:0]                       chk_next;
    logic [7:0]                       nib;
    logic [7:0]                       pair;
    logic                             in_range;
    logic                             is_stx;
    logic                             closing;
    logic                             frame_ok;
    logic                             do_update;

    assign in_range  = (32'(reader_id) < NUM_READERS);
    assign is_stx    = (rx_byte == rfc_pkg::STX_CHAR);
    assign do_update = accept && in_range;
    assign nib       = rfc_pkg::decode_char(rx_byte);

    always_comb begin
        logic [rfc_pkg::CHAR_COUNT_W-1:0] pos;
        pos        = count_reg[reader_id];
        hi_next    = hi_reg[reader_id];
        tag_next   = tag_reg[reader_id];
        xor_next   = xor_reg[reader_id];
        chk_next   = chk_reg[reader_id];
        pair       = nib | 8'(hi_reg[reader_id] << 4);
        if (pos < rfc_pkg::MIN_FRAME_CHARS) begin
            if (!pos[0]) begin
                hi_next = nib;
            end else if (pos[4:1] < rfc_pkg::CHECK_SLOT) begin
                xor_next = xor_reg[reader_id] ^ pair;
                tag_next = {tag_reg[reader_id][rfc_pkg::TAG_W-9:0], pair};
            end else begin
                chk_next = pair;
            end
        end
        count_next = (pos < rfc_pkg::COUNT_MAX) ? pos + 1'b1 : pos;
        closing    = (rx_byte == rfc_pkg::ETX_CHAR) || !(count_next < max_chars_reg);
        frame_ok   = (count_next >= rfc_pkg::MIN_FRAME_CHARS) && (xor_next == chk_next);
    end

    assign push             = do_update && !is_stx && closing && frame_ok;
    assign push_data.reader = reader_id;
    assign push_data.tag    = tag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= rfc_pkg::MAX_FRAME_CHARS_RST;
        end else if (cfg_wr_en) begin
            max_chars_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_READERS; r++) begin
                count_reg[r] <= '0;
                hi_reg[r]    <= '0;
                tag_reg[r]   <= '0;
                xor_reg[r]   <= '0;
                chk_reg[r]   <= '0;
            end
        end else if (do_update) begin
            if (is_stx || closing) begin
                count_reg[reader_id] <= '0;
                hi_reg[reader_id]    <= '0;
                tag_reg[reader_id]   <= '0;
                xor_reg[reader_id]   <= '0;
                chk_reg[reader_id]   <= '0;
            end else begin
                count_reg[reader_id] <= count_next;
                hi_reg[reader_id]    <= hi_next;
                tag_reg[reader_id]   <= tag_next;
                xor_reg[reader_id]   <= xor_next;
                chk_reg[reader_id]   <= chk_next;
            end
        end
    end

endmodule

>>> src/rfc_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of checked frames between front and back end.
// Depends on rfc_pkg.
module rfc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rfc_pkg::cand_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output rfc_pkg::cand_t head
);

    rfc_pkg::cand_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

>>> src/rfc_back.sv
`timescale 1ns / 1ps
// Back end: drops repeats of the last published tag, holds the output register.
// Depends on rfc_pkg.
module rfc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  rfc_pkg::cand_t             head,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_reader_number,
    output logic [rfc_pkg::TAG_W-1:0]  m_tag_id
);

    logic [rfc_pkg::TAG_W-1:0] last_tag_reg;
    logic                      last_valid_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    rfc_pkg::cand_t            out_reg;
    logic                      out_free;
    logic                      emit;

    assign out_free = !out_valid_reg || m_ready;
    assign pop      = head_valid && out_free;
    assign emit     = pop && (!last_valid_reg || head.tag != last_tag_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
            last_tag_reg   <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (emit) begin
                last_valid_reg <= 1'b1;
                last_tag_reg   <= head.tag;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_reader_number = out_reg.reader;
    assign m_tag_id        = out_reg.tag;

endmodule

>>> src/rfc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the RFID frame checker, bound to the top level.
// Depends on rfc_pkg and rfid_ascii_frame_checker.
module rfc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_reader_number,
    input logic [rfc_pkg::TAG_W-1:0]         m_tag_id
);

    // nothing can be pending right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output valid or input not ready after reset");

    // a stalled request holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tag_id) && $stable(m_reader_number))
        else $error("stalled output request changed");

    // repeats of the published tag are filtered
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) ##1 (m_valid && m_ready) |-> m_tag_id != $past(m_tag_id))
        else $error("same tag delivered twice in a row");

    // input can only back up while the output is stalled
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid) && !$past(m_ready))
        else $error("input stalled without an output stall");

endmodule

bind rfid_ascii_frame_checker rfc_checker u_rfc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_reader_number (m_reader_number),
    .m_tag_id        (m_tag_id)
);
